// ===== sv/hdr_exposure_gamma_tonemap_core_macros.svh =====
// ============================================================================
// HDR tone mapper assertion macros
// Shared concurrent assertion forms for the tone mapper checker.
// ============================================================================
`ifndef HDR_EXPOSURE_GAMMA_TONEMAP_CORE_MACROS_SVH
`define HDR_EXPOSURE_GAMMA_TONEMAP_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define HETM_ASSERT_NOW(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define HETM_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/hetm_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// HDR tone mapper package
// Shared types, float field constants and constant ROM builders.
// ============================================================================
package hetm_pkg;

    // IEEE single fields
    localparam int FLT_MAN_W = 23;
    localparam int FLT_EXP_W = 8;
    localparam logic [FLT_EXP_W-1:0] FLT_EXP_MAX = 8'hFF;
    localparam int FLT_EXP_BIAS = 127;

    // register widths and reset values
    localparam int EXPOSURE_W  = 14;
    localparam int INV_GAMMA_W = 16;
    localparam int GAMMA_FRAC  = 14;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam logic signed [EXPOSURE_W-1:0] EXPOSURE_RST = '0;
    localparam logic [INV_GAMMA_W-1:0] INV_GAMMA_RST = 16'd7447;

    // exposure is Q.8
    localparam int EXPOSURE_FRAC = 8;

    // exp ROM format
    localparam int Q30_BITS = 30;
    localparam int EXP_ROM_W = 32;
    localparam int PIX_W = 8;
    localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;
    localparam int SHIFT_W = 4;
    localparam int MAX_SHIFT = 8;

    // pipeline split
    localparam int LOG_STAGES  = 2;
    localparam int EXP_STAGES  = 5;
    localparam int PIPE_STAGES = LOG_STAGES + EXP_STAGES;
    localparam int NUM_CHAN = 3;

    // upper bounds of the table parameters, for constant loops
    localparam int MAX_TABLE_BITS = 12;
    localparam int MAX_FRAC_BITS  = 24;

    typedef enum logic [1:0] {
        CH_CALC = 2'd0,
        CH_ZERO = 2'd1,
        CH_FULL = 2'd2
    } chan_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_EXPOSURE     = 2'd0,
        CFG_INV_GAMMA    = 2'd1,
        CFG_SHOW_INVALID = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        PIX_NORMAL = 2'd0,
        PIX_NAN    = 2'd1,
        PIX_NEG    = 2'd2
    } pix_class_t;

    // digit-by-digit integer square root, elaboration only
    function automatic logic [63:0] hetm_isqrt(input logic [63:0] a_in);
        logic [63:0] a;
        logic [63:0] r;
        logic [63:0] b;
        a = a_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++) begin
            if (a >= r + b) begin
                a = a - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2(1 + i/2^tb) with fb fraction bits, by repeated squaring in Q1.30
    function automatic logic [31:0] hetm_log_entry(input int i, input int tb, input int fb);
        logic [63:0] x;
        logic [63:0] r;
        if (i == (1 << tb)) begin
            return 32'(64'd1 << fb);
        end
        x = 64'((1 << tb) + i) << (Q30_BITS - tb);
        r = '0;
        for (int k = 0; k < MAX_FRAC_BITS; k++) begin
            if (k < fb) begin
                x = (x * x) >> Q30_BITS;
                r = r << 1;
                if (x >= (64'd2 << Q30_BITS)) begin
                    r = r | 64'd1;
                    x = x >> 1;
                end
            end
        end
        return r[31:0];
    endfunction

    // 2^(i/2^tb) in Q2.30 as a product of 2^(2^-k) roots
    function automatic logic [31:0] hetm_exp_entry(input int i, input int tb);
        logic [63:0] root;
        logic [63:0] acc;
        if (i == (1 << tb)) begin
            return 32'(64'd2 << Q30_BITS);
        end
        root = 64'd2 << Q30_BITS;
        acc  = 64'd1 << Q30_BITS;
        for (int k = 1; k <= MAX_TABLE_BITS; k++) begin
            if (k <= tb) begin
                root = hetm_isqrt(root << Q30_BITS);
                if (((i >> (tb - k)) & 1) != 0) begin
                    acc = (acc * root) >> Q30_BITS;
                end
            end
        end
        return acc[31:0];
    endfunction

endpackage

// ===== sv/hetm_log.sv =====
`timescale 1ns / 1ps
// ============================================================================
// HDR tone mapper log2 front end
// Two stages: float decode with log ROM read, then interpolation and the
// exponent and exposure sums.
// ============================================================================
module hetm_log
    import hetm_pkg::*;
#(
    parameter int LOG_TABLE_BITS = 8,
    parameter int LOG_FRAC_BITS  = 16
)
(
    input  logic                                 clk,
    input  logic [LOG_STAGES-1:0]                stage_en,
    input  logic [31:0]                          chan_in,
    input  chan_mode_t                           mark_mode,
    input  logic signed [EXPOSURE_W-1:0]         exposure,
    output logic signed [LOG_FRAC_BITS+8:0]      lg,
    output chan_mode_t                           mode
);

    localparam int LG_W   = LOG_FRAC_BITS + 9;
    localparam int RSH    = FLT_MAN_W - LOG_TABLE_BITS;
    localparam int TAB    = (1 << LOG_TABLE_BITS) + 1;
    localparam int EXP_SH = LOG_FRAC_BITS - EXPOSURE_FRAC;

    logic [LOG_FRAC_BITS:0] log_rom [TAB];

    for (genvar gi = 0; gi < TAB; gi++) begin : g_rom
        localparam logic [31:0] LV = hetm_log_entry(gi, LOG_TABLE_BITS, LOG_FRAC_BITS);
        assign log_rom[gi] = LV[LOG_FRAC_BITS:0];
    end

    // ---- stage 1: decode and table read
    logic [FLT_EXP_W-1:0]      exp_fld;
    logic [FLT_MAN_W-1:0]      man_fld;
    logic [LOG_TABLE_BITS:0]   idx_lo;
    logic [LOG_TABLE_BITS:0]   idx_hi;
    logic [LOG_FRAC_BITS:0]    rom_lo;
    logic [LOG_FRAC_BITS:0]    rom_hi;
    chan_mode_t                mode1_next;
    chan_mode_t                mode1_reg;
    logic [FLT_EXP_W-1:0]      e1_reg;
    logic [LOG_FRAC_BITS:0]    lo1_reg;
    logic [LOG_FRAC_BITS:0]    dl1_next;
    logic [LOG_FRAC_BITS:0]    dl1_reg;
    logic [RSH-1:0]            rest1_reg;

    assign exp_fld = chan_in[30:23];
    assign man_fld = chan_in[22:0];
    assign idx_lo  = {1'b0, man_fld[FLT_MAN_W-1:RSH]};
    assign idx_hi  = idx_lo + 1'b1;
    assign rom_lo  = log_rom[idx_lo];
    assign rom_hi  = log_rom[idx_hi];
    assign dl1_next = (rom_hi > rom_lo) ? (rom_hi - rom_lo) : '0;

    always_comb begin
        if (mark_mode != CH_CALC) begin
            mode1_next = mark_mode;
        end else if (chan_in[31] || exp_fld == '0) begin
            mode1_next = CH_ZERO;
        end else if (exp_fld == FLT_EXP_MAX) begin
            mode1_next = (man_fld != '0) ? CH_ZERO : CH_FULL;
        end else begin
            mode1_next = CH_CALC;
        end
    end

    always_ff @(posedge clk) begin
        if (stage_en[0]) begin
            mode1_reg <= mode1_next;
            e1_reg    <= exp_fld;
            lo1_reg   <= rom_lo;
            dl1_reg   <= dl1_next;
            rest1_reg <= man_fld[RSH-1:0];
        end
    end

    // ---- stage 2: interpolate, add exponent and exposure
    logic [LOG_FRAC_BITS+RSH:0] prod2;
    logic [LOG_FRAC_BITS:0]     step2;
    logic signed [FLT_EXP_W:0]  ex_unb;
    logic signed [LG_W-1:0]     lg2_next;
    logic signed [LG_W-1:0]     lg2_reg;
    chan_mode_t                 mode2_reg;

    assign prod2  = dl1_reg * rest1_reg;
    assign step2  = prod2[LOG_FRAC_BITS+RSH:RSH];
    assign ex_unb = $signed({1'b0, e1_reg}) - (FLT_EXP_W+1)'(FLT_EXP_BIAS);
    assign lg2_next = LG_W'($signed({1'b0, lo1_reg}))
                    + LG_W'($signed({1'b0, step2}))
                    + (LG_W'(ex_unb) <<< LOG_FRAC_BITS)
                    + (LG_W'(exposure) <<< EXP_SH);

    always_ff @(posedge clk) begin
        if (stage_en[1]) begin
            lg2_reg   <= lg2_next;
            mode2_reg <= mode1_reg;
        end
    end

    assign lg   = lg2_reg;
    assign mode = mode2_reg;

endmodule

// ===== sv/hetm_exp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// HDR tone mapper gamma and exp2 back end
// Five stages: gamma multiply, split into shift and fraction, exp ROM read,
// interpolation, scale to 8 bits with clamp.
// ============================================================================
module hetm_exp
    import hetm_pkg::*;
#(
    parameter int LOG_TABLE_BITS = 8,
    parameter int LOG_FRAC_BITS  = 16
)
(
    input  logic                             clk,
    input  logic [EXP_STAGES-1:0]            stage_en,
    input  logic signed [LOG_FRAC_BITS+8:0]  lg,
    input  chan_mode_t                       mode,
    input  logic [INV_GAMMA_W-1:0]           inv_gamma,
    output logic [PIX_W-1:0]                 chan_out
);

    localparam int LG_W = LOG_FRAC_BITS + 9;
    localparam int P_W  = LG_W + INV_GAMMA_W + 1;
    localparam int YM_W = P_W + 1 - GAMMA_FRAC;
    localparam int NF_W = YM_W - LOG_FRAC_BITS;
    localparam int TAB  = (1 << LOG_TABLE_BITS) + 1;
    localparam int SC_W = EXP_ROM_W + PIX_W;
    localparam int HI_W = SC_W - Q30_BITS;

    logic [EXP_ROM_W-1:0] exp_rom [TAB];

    for (genvar gi = 0; gi < TAB; gi++) begin : g_rom
        localparam logic [31:0] EV = hetm_exp_entry(gi, LOG_TABLE_BITS);
        assign exp_rom[gi] = EV;
    end

    // ---- stage 3: times inverse gamma
    logic signed [P_W-1:0] p3_next;
    logic signed [P_W-1:0] p3_reg;
    chan_mode_t            mode3_reg;

    assign p3_next = lg * $signed({1'b0, inv_gamma});

    always_ff @(posedge clk) begin
        if (stage_en[0]) begin
            p3_reg    <= p3_next;
            mode3_reg <= mode;
        end
    end

    // ---- stage 4: y = -ceil(-p / 2^14) split as -n + f
    logic [P_W-1:0]           mag4;
    logic [P_W:0]             sum4;
    logic [YM_W-1:0]          ymag4;
    logic [LOG_FRAC_BITS-1:0] fraw4;
    logic [NF_W:0]            nadj4;
    chan_mode_t               mode4_next;
    chan_mode_t               mode4_reg;
    logic [SHIFT_W-1:0]       n4_reg;
    logic [LOG_FRAC_BITS-1:0] fexp4_reg;

    assign mag4  = -p3_reg;
    assign sum4  = {1'b0, mag4} + (P_W+1)'((1 << GAMMA_FRAC) - 1);
    assign ymag4 = sum4[P_W:GAMMA_FRAC];
    assign fraw4 = ymag4[LOG_FRAC_BITS-1:0];
    assign nadj4 = {1'b0, ymag4[YM_W-1:LOG_FRAC_BITS]} + (NF_W+1)'(fraw4 != '0);

    always_comb begin
        if (mode3_reg != CH_CALC) begin
            mode4_next = mode3_reg;
        end else if (!p3_reg[P_W-1]) begin
            mode4_next = CH_FULL;
        end else if (nadj4 > (NF_W+1)'(MAX_SHIFT)) begin
            mode4_next = CH_ZERO;
        end else begin
            mode4_next = CH_CALC;
        end
    end

    always_ff @(posedge clk) begin
        if (stage_en[1]) begin
            mode4_reg <= mode4_next;
            n4_reg    <= nadj4[SHIFT_W-1:0];
            fexp4_reg <= -fraw4;
        end
    end

    // ---- stages 5 and 6: exp ROM read and interpolation
    logic [EXP_ROM_W-1:0] ee6_reg;
    chan_mode_t           mode5_reg;
    chan_mode_t           mode6_reg;
    logic [SHIFT_W-1:0]   n5_reg;
    logic [SHIFT_W-1:0]   n6_reg;

    if (LOG_FRAC_BITS > LOG_TABLE_BITS) begin : g_interp
        localparam int ESH = LOG_FRAC_BITS - LOG_TABLE_BITS;

        logic [LOG_TABLE_BITS:0]  idx_lo;
        logic [LOG_TABLE_BITS:0]  idx_hi;
        logic [EXP_ROM_W-1:0]     rom_lo;
        logic [EXP_ROM_W-1:0]     rom_hi;
        logic [EXP_ROM_W-1:0]     lo5_reg;
        logic [EXP_ROM_W-1:0]     dl5_reg;
        logic [ESH-1:0]           rest5_reg;
        logic [EXP_ROM_W+ESH-1:0] prod6;

        assign idx_lo = {1'b0, fexp4_reg[LOG_FRAC_BITS-1:ESH]};
        assign idx_hi = idx_lo + 1'b1;
        assign rom_lo = exp_rom[idx_lo];
        assign rom_hi = exp_rom[idx_hi];
        assign prod6  = dl5_reg * rest5_reg;

        always_ff @(posedge clk) begin
            if (stage_en[2]) begin
                lo5_reg   <= rom_lo;
                dl5_reg   <= (rom_hi > rom_lo) ? (rom_hi - rom_lo) : '0;
                rest5_reg <= fexp4_reg[ESH-1:0];
            end
            if (stage_en[3]) begin
                ee6_reg <= lo5_reg + prod6[EXP_ROM_W+ESH-1:ESH];
            end
        end
    end else begin : g_direct
        logic [LOG_TABLE_BITS:0] idx_lo;
        logic [EXP_ROM_W-1:0]    lo5_reg;

        assign idx_lo = {1'b0, LOG_TABLE_BITS'(fexp4_reg) << (LOG_TABLE_BITS - LOG_FRAC_BITS)};

        always_ff @(posedge clk) begin
            if (stage_en[2]) begin
                lo5_reg <= exp_rom[idx_lo];
            end
            if (stage_en[3]) begin
                ee6_reg <= lo5_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (stage_en[2]) begin
            mode5_reg <= mode4_reg;
            n5_reg    <= n4_reg;
        end
        if (stage_en[3]) begin
            mode6_reg <= mode5_reg;
            n6_reg    <= n5_reg;
        end
    end

    // ---- stage 7: (255 * E) >> (30 + n), clamp
    logic [SC_W-1:0]  scaled7;
    logic [HI_W-1:0]  shifted7;
    logic [PIX_W-1:0] out7_next;
    logic [PIX_W-1:0] out7_reg;

    assign scaled7  = {ee6_reg, {PIX_W{1'b0}}} - SC_W'(ee6_reg);
    assign shifted7 = scaled7[SC_W-1:Q30_BITS] >> n6_reg;

    always_comb begin
        case (mode6_reg)
            CH_FULL: out7_next = PIX_FULL;
            CH_ZERO: out7_next = '0;
            default: out7_next = (shifted7 > HI_W'(PIX_FULL)) ? PIX_FULL
                                                               : shifted7[PIX_W-1:0];
        endcase
    end

    always_ff @(posedge clk) begin
        if (stage_en[4]) begin
            out7_reg <= out7_next;
        end
    end

    assign chan_out = out7_reg;

endmodule

// ===== sv/hdr_exposure_gamma_tonemap_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// HDR exposure and gamma tone mapper
// Maps a pixel of three IEEE single channels to 8-bit RGB through log2,
// exposure, inverse gamma and exp2.
// ============================================================================
// Each channel c becomes floor(255 * (c * 2^exposure)^inv_gamma), clamped to
// 0..255; zero, denormal, negative and NaN channels give 0 and +inf gives 255.
// Throughput is one pixel per clock while out_stall is low. The pipeline
// stages are, in order: float decode and log ROM read, interpolation with
// exponent and exposure sums, inverse gamma multiply, split into integer
// shift and fraction, exp ROM read, interpolation, and scaling to 8 bits.
// Bubbles collapse: a stalled output holds back only the unbroken run of
// full stages before it, so in_stall rises only when all seven hold words.
// Both ROMs are constant logic computed at elaboration, so there is no fill
// pass after reset. The configuration port is always ready; registers must
// be written only while the pipeline is empty. With show_invalid set, a
// pixel with any NaN channel comes out pure red (class 1), else one with any
// negative nonzero channel comes out pure green (class 2).
// ============================================================================
module hdr_exposure_gamma_tonemap_core
    import hetm_pkg::*;
#(
    parameter int LOG_TABLE_BITS = 8,
    parameter int LOG_FRAC_BITS  = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [31:0]            red_in,
    input  logic [31:0]            green_in,
    input  logic [31:0]            blue_in,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [PIX_W-1:0]       red_out,
    output logic [PIX_W-1:0]       green_out,
    output logic [PIX_W-1:0]       blue_out,
    output logic [1:0]             pixel_class,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [EXPOSURE_W-1:0] exposure_reg;
    logic [INV_GAMMA_W-1:0]       inv_gamma_reg;
    logic                         show_invalid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            exposure_reg     <= EXPOSURE_RST;
            inv_gamma_reg    <= INV_GAMMA_RST;
            show_invalid_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_EXPOSURE:     exposure_reg     <= $signed(cfg_data[EXPOSURE_W-1:0]);
                CFG_INV_GAMMA:    inv_gamma_reg    <= cfg_data[INV_GAMMA_W-1:0];
                CFG_SHOW_INVALID: show_invalid_reg <= cfg_data[0];
                default:          ; // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or its successor
    // loads, so bubbles are squeezed out under a stalled output.
    // ------------------------------------------------------------------
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES-1:0] stage_en;

    always_comb begin
        stage_en[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || !out_stall;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    always_comb begin
        valid_next[0] = stage_en[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < PIPE_STAGES; k++) begin
            valid_next[k] = stage_en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !stage_en[0];
    assign out_valid = valid_reg[PIPE_STAGES-1];

    // ------------------------------------------------------------------
    // Invalid-pixel marking, decided at entry and forced per channel
    // ------------------------------------------------------------------
    logic [31:0] chan_in  [NUM_CHAN];
    logic [PIX_W-1:0] chan_out [NUM_CHAN];
    chan_mode_t  mark_mode [NUM_CHAN];
    logic [NUM_CHAN-1:0] is_nan;
    logic [NUM_CHAN-1:0] is_neg;
    pix_class_t  class_next;

    assign chan_in[0] = red_in;
    assign chan_in[1] = green_in;
    assign chan_in[2] = blue_in;

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            is_nan[c] = (chan_in[c][30:23] == FLT_EXP_MAX) && (chan_in[c][22:0] != '0);
            is_neg[c] = chan_in[c][31] && (chan_in[c][30:0] != '0) && !is_nan[c];
        end
    end

    always_comb begin
        if (show_invalid_reg && (is_nan != '0)) begin
            class_next   = PIX_NAN;
            mark_mode[0] = CH_FULL;
            mark_mode[1] = CH_ZERO;
            mark_mode[2] = CH_ZERO;
        end else if (show_invalid_reg && (is_neg != '0)) begin
            class_next   = PIX_NEG;
            mark_mode[0] = CH_ZERO;
            mark_mode[1] = CH_FULL;
            mark_mode[2] = CH_ZERO;
        end else begin
            class_next   = PIX_NORMAL;
            mark_mode[0] = CH_CALC;
            mark_mode[1] = CH_CALC;
            mark_mode[2] = CH_CALC;
        end
    end

    // class travels alongside the channel data
    pix_class_t class_reg [PIPE_STAGES];

    always_ff @(posedge clk) begin
        if (stage_en[0]) begin
            class_reg[0] <= class_next;
        end
        for (int k = 1; k < PIPE_STAGES; k++) begin
            if (stage_en[k]) begin
                class_reg[k] <= class_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Three channel pipelines
    // ------------------------------------------------------------------
    for (genvar gc = 0; gc < NUM_CHAN; gc++) begin : g_chan
        logic signed [LOG_FRAC_BITS+8:0] lg;
        chan_mode_t                      mode;

        hetm_log #(
            .LOG_TABLE_BITS (LOG_TABLE_BITS),
            .LOG_FRAC_BITS  (LOG_FRAC_BITS)
        ) u_log (
            .clk       (clk),
            .stage_en  (stage_en[LOG_STAGES-1:0]),
            .chan_in   (chan_in[gc]),
            .mark_mode (mark_mode[gc]),
            .exposure  (exposure_reg),
            .lg        (lg),
            .mode      (mode)
        );

        hetm_exp #(
            .LOG_TABLE_BITS (LOG_TABLE_BITS),
            .LOG_FRAC_BITS  (LOG_FRAC_BITS)
        ) u_exp (
            .clk       (clk),
            .stage_en  (stage_en[PIPE_STAGES-1:LOG_STAGES]),
            .lg        (lg),
            .mode      (mode),
            .inv_gamma (inv_gamma_reg),
            .chan_out  (chan_out[gc])
        );
    end

    assign red_out     = chan_out[0];
    assign green_out   = chan_out[1];
    assign blue_out    = chan_out[2];
    assign pixel_class = class_reg[PIPE_STAGES-1];

endmodule

// ===== sv/hetm_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// HDR tone mapper port checker
// Watches the top-level ports for output hold, stall cause and marker colors.
// ============================================================================
`include "hdr_exposure_gamma_tonemap_core_macros.svh"

module hetm_checker
    import hetm_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [PIX_W-1:0] red_out,
    input logic [PIX_W-1:0] green_out,
    input logic [PIX_W-1:0] blue_out,
    input logic [1:0]       pixel_class
);

    // a stalled output word holds
    `HETM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(pixel_class), "output word changed under stall")

    // input only backs up when the full pipe sits behind a stalled output
    `HETM_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled with room in pipeline")

    `HETM_ASSERT_NOW(a_nan_red, clk, rst_n, out_valid && pixel_class == PIX_NAN, red_out == PIX_FULL && green_out == '0 && blue_out == '0, "NaN marker is not pure red")

    `HETM_ASSERT_NOW(a_neg_green, clk, rst_n, out_valid && pixel_class == PIX_NEG, red_out == '0 && green_out == PIX_FULL && blue_out == '0, "negative marker is not pure green")

endmodule

bind hdr_exposure_gamma_tonemap_core hetm_checker u_hetm_checker (.*);

// ===== tb/sv/tonemap_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Tone mapper scoreboard
// Bit-exact pixel prediction and in-order result checking for the HDR
// exposure and gamma tone mapper.
// ============================================================================
package tonemap_scoreboard_pkg;

    import hetm_pkg::*;

    localparam int LUT_BITS = 8;
    localparam int LUT_FRAC = 16;
    localparam int LUT_SIZE = (1 << LUT_BITS) + 1;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        pix_class_t       cls;
    } rgb_word_t;

    class tonemap_scoreboard;

        logic [31:0] log_lut [LUT_SIZE];
        logic [31:0] exp_lut [LUT_SIZE];

        logic signed [EXPOSURE_W-1:0] exposure;
        logic [INV_GAMMA_W-1:0]       inv_gamma;
        logic                         show_invalid;

        rgb_word_t expected_rgb[$];

        int errors;
        int sent;
        int compared;
        int red_marks;
        int green_marks;
        int full_chans;
        int zero_chans;

        function new();
            logic [63:0] roots [LUT_BITS+1];
            logic [63:0] x;
            logic [63:0] r;
            logic [63:0] acc;
            roots[0] = 64'd2 << Q30_BITS;
            for (int k = 1; k <= LUT_BITS; k++)
                roots[k] = isqrt64(roots[k-1] << Q30_BITS);
            for (int i = 0; i < (1 << LUT_BITS); i++)
            begin
                // log2 of 1 + i/256 by squaring, one result bit per pass
                x   = 64'((1 << LUT_BITS) + i) << (Q30_BITS - LUT_BITS);
                r   = '0;
                acc = 64'd1 << Q30_BITS;
                for (int k = 0; k < LUT_FRAC; k++)
                begin
                    x = (x * x) >> Q30_BITS;
                    r = r << 1;
                    if (x >= (64'd2 << Q30_BITS))
                    begin
                        r = r | 64'd1;
                        x = x >> 1;
                    end
                end
                log_lut[i] = r[31:0];
                // 2^(i/256) as a product of 2^(2^-k) roots
                for (int k = 1; k <= LUT_BITS; k++)
                    if (((i >> (LUT_BITS - k)) & 1) != 0)
                        acc = (acc * roots[k]) >> Q30_BITS;
                exp_lut[i] = acc[31:0];
            end
            log_lut[1 << LUT_BITS] = 32'd1 << LUT_FRAC;
            exp_lut[1 << LUT_BITS] = 32'h8000_0000;
            exposure     = EXPOSURE_RST;
            inv_gamma    = INV_GAMMA_RST;
            show_invalid = 1'b0;
        endfunction

        function logic [63:0] isqrt64(logic [63:0] a_in);
            logic [63:0] a;
            logic [63:0] r;
            logic [63:0] b;
            a = a_in;
            r = '0;
            b = 64'd1 << 62;
            while (b > a)
                b = b >> 2;
            while (b != 0)
            begin
                if (a >= r + b)
                begin
                    a = a - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // linear step between neighbor entries; a falling pair adds nothing
        function logic [63:0] lut_step(logic [31:0] lo, logic [31:0] hi,
                                       logic [63:0] rest, int sh);
            logic [63:0] d;
            d = (hi > lo) ? 64'(hi - lo) : 64'd0;
            return (d * rest) >> sh;
        endfunction

        function logic [PIX_W-1:0] tone_channel(logic [31:0] v);
            logic [FLT_EXP_W-1:0] e;
            logic [FLT_MAN_W-1:0] m;
            int          li;
            int          xi;
            longint      lg;
            longint      p;
            longint      y;
            logic [63:0] u;
            logic [63:0] n;
            logic [63:0] ee;
            logic [63:0] val;
            logic [31:0] fexp;
            e = v[30:23];
            m = v[22:0];
            if (v[31] || e == '0)
                return '0;
            if (e == FLT_EXP_MAX)
                return (m != '0) ? '0 : PIX_FULL;
            li = int'(m[22:15]);
            lg = longint'(log_lut[li])
               + longint'(lut_step(log_lut[li], log_lut[li+1], 64'(m[14:0]), 15));
            lg = lg + (longint'(e) - FLT_EXP_BIAS) * (longint'(1) << LUT_FRAC);
            lg = lg + longint'(exposure) * (longint'(1) << (LUT_FRAC - EXPOSURE_FRAC));
            p  = lg * longint'(inv_gamma);
            if (p >= 0)
                return PIX_FULL;
            // floor of p / 2^14
            u = 64'(-p);
            y = -longint'((u + 64'd16383) >> GAMMA_FRAC);
            if (y >= 0)
                return PIX_FULL;
            // y = -n + f, f in [0,1)
            u    = 64'(-y);
            n    = u >> LUT_FRAC;
            fexp = 32'(u & 64'hFFFF);
            if (fexp != 0)
            begin
                n    = n + 1;
                fexp = 32'h1_0000 - fexp;
            end
            if (n > MAX_SHIFT)
                return '0;
            xi  = int'(fexp >> (LUT_FRAC - LUT_BITS));
            ee  = 64'(exp_lut[xi])
                + lut_step(exp_lut[xi], exp_lut[xi+1], 64'(fexp & 32'hFF),
                           LUT_FRAC - LUT_BITS);
            val = (64'd255 * ee) >> (Q30_BITS + n);
            return (val > 64'd255) ? PIX_FULL : val[7:0];
        endfunction

        function rgb_word_t predict_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b);
            logic [31:0] chan [NUM_CHAN];
            logic        any_nan;
            logic        any_neg;
            rgb_word_t   w;
            chan    = '{r, g, b};
            any_nan = 1'b0;
            any_neg = 1'b0;
            foreach (chan[c])
            begin
                if (chan[c][30:23] == FLT_EXP_MAX && chan[c][22:0] != '0)
                    any_nan = 1'b1;
                else if (chan[c][31] && chan[c][30:0] != '0)
                    any_neg = 1'b1;
            end
            if (show_invalid && any_nan)
                w = '{PIX_FULL, '0, '0, PIX_NAN};
            else if (show_invalid && any_neg)
                w = '{'0, PIX_FULL, '0, PIX_NEG};
            else
                w = '{tone_channel(r), tone_channel(g), tone_channel(b), PIX_NORMAL};
            return w;
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_EXPOSURE:     exposure     = data[EXPOSURE_W-1:0];
                CFG_INV_GAMMA:    inv_gamma    = data[INV_GAMMA_W-1:0];
                CFG_SHOW_INVALID: show_invalid = data[0];
                default:          ;
            endcase
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("ERROR @%0t: %s", $time, msg);
        endfunction

        function void note_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b);
            expected_rgb.push_back(predict_pixel(r, g, b));
            sent++;
        endfunction

        function void check_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                  logic [PIX_W-1:0] b, logic [1:0] cls);
            rgb_word_t want;
            if (expected_rgb.size() == 0)
            begin
                report($sformatf("pixel %0d/%0d/%0d class %0d with none pending",
                                 r, g, b, cls));
                return;
            end
            want = expected_rgb.pop_front();
            compared++;
            if (r !== want.red)
                report($sformatf("pixel %0d red %0d, want %0d", compared, r, want.red));
            if (g !== want.green)
                report($sformatf("pixel %0d green %0d, want %0d", compared, g, want.green));
            if (b !== want.blue)
                report($sformatf("pixel %0d blue %0d, want %0d", compared, b, want.blue));
            if (cls !== want.cls)
                report($sformatf("pixel %0d class %0d, want %0d", compared, cls, want.cls));
            if (want.cls == PIX_NAN)
                red_marks++;
            else if (want.cls == PIX_NEG)
                green_marks++;
            else
            begin
                full_chans += (want.red == PIX_FULL) + (want.green == PIX_FULL)
                            + (want.blue == PIX_FULL);
                zero_chans += (want.red == '0) + (want.green == '0) + (want.blue == '0);
            end
        endfunction

        function int pending();
            return expected_rgb.size();
        endfunction

    endclass

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Tone mapper testbench
// Streams HDR pixels through the tone mapper under several register
// settings and compares every 8-bit output word with a bit-exact prediction.
// ============================================================================
module testbench;

    import hetm_pkg::*;
    import tonemap_scoreboard_pkg::*;

    // 7-stage pipe; the tail wait covers it with margin
    localparam int TAIL_CYCLES  = 24;
    // this limit is far beyond the slowest legal run
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 10;
    localparam int PHASE_PIXELS = 125;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // input word channel
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] red_in   = '0;
    logic [31:0] green_in = '0;
    logic [31:0] blue_in  = '0;

    // output word channel
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic [1:0]       pixel_class;

    // register write channel
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // percent of cycles each side sits out
    int send_idle_pct = 15;
    int hold_pct      = 52;

    int cycle_count = 0;
    int settings    = 0;

    tonemap_scoreboard pixel_sb = new();

    hdr_exposure_gamma_tonemap_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .pixel_class (pixel_class),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #6 clk = ~clk;

    // Watchdog: a hung handshake or a lost word ends here.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d pixels still pending",
                     cycle_count, pixel_sb.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: output signals are read at the edge, before the design's
    // flops update, so a word counts when valid and our stall were both
    // in place during the cycle just ended. Stall is redrawn each cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                pixel_sb.check_pixel(red_out, green_out, blue_out, pixel_class);
            out_stall <= ($urandom_range(0, 99) < hold_pct);
        end
    end

    // Offer one input word, with an optional random gap first. Valid stays
    // high on return so back-to-back words need no second assignment in
    // the same step.
    task automatic push_pixel(input logic [31:0] r, input logic [31:0] g,
                              input logic [31:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pixel_sb.note_pixel(r, g, b);
    endtask

    // Stop sending and let the pipe empty. Always waits on the clock before
    // checking the queue, so the lowered valid is never overridden in the same step.
    task automatic wait_pipe_empty();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pixel_sb.pending() != 0)
            @(posedge clk);
    endtask

    // Registers only change with the pipe empty: every pixel causes exactly
    // one output word, so an empty queue means nothing is in flight.
    task automatic load_settings(input int expo, input int gamma, input bit show);
        cfg_index_t             idx_list  [3];
        logic [CFG_DATA_W-1:0]  data_list [3];
        idx_list  = '{CFG_EXPOSURE, CFG_INV_GAMMA, CFG_SHOW_INVALID};
        data_list = '{16'(expo), 16'(gamma), 16'(show)};
        wait_pipe_empty();
        foreach (idx_list[k])
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[k];
            cfg_data  <= data_list[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            pixel_sb.set_register(idx_list[k], data_list[k]);
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // Mostly positive normals around unity so the log/exp path does real
    // work; the rest are the corner encodings and raw noise.
    function automatic logic [31:0] rand_channel();
        int                   sel;
        logic [FLT_MAN_W-1:0] man;
        sel = $urandom_range(0, 99);
        man = FLT_MAN_W'($urandom);
        if (sel < 62)
            return {1'b0, 8'($urandom_range(100, 140)), man};
        else if (sel < 72)
            return $urandom;
        else if (sel < 76)
            return {1'b1, 8'($urandom_range(100, 140)), man};
        else if (sel < 80)
            return {1'($urandom), 31'd0};
        else if (sel < 84)
            return {1'($urandom), 8'd0, man | 23'd1};
        else if (sel < 88)
            return {1'($urandom), FLT_EXP_MAX, 23'd0};
        else if (sel < 92)
            return {1'($urandom), FLT_EXP_MAX, man | 23'd1};
        else
            return {1'b0, 8'($urandom_range(1, 254)), man};
    endfunction

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: reset settings, markers off ----
        push_pixel(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);   // zeros
        push_pixel(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);   // 1.0 clamps
        push_pixel(32'h3F00_0000, 32'h3E80_0000, 32'h3C23_D70A);   // 0.5 .25 .01
        push_pixel(32'h0000_0001, 32'h007F_FFFF, 32'h8000_0000);   // denormals, -0
        push_pixel(32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000);   // +inf -inf NaN
        push_pixel(32'hBF80_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF);   // neg, NaN, max
        push_pixel(32'h0080_0000, 32'h3F7F_FFFF, 32'h3B80_0000);   // tiny, <1, 2^-8
        push_pixel(32'h7FFF_FFFF, 32'h3FFF_FFFF, 32'h3A00_0001);
        push_pixel(32'h3E4C_CCCD, 32'h3D00_0000, 32'h3F40_0000);

        // ---- directed: markers on ----
        load_settings(0, 7447, 1'b1);
        push_pixel(32'h7FC0_0000, 32'hBF80_0000, 32'h3F00_0000);   // NaN wins: red
        push_pixel(32'h3F00_0000, 32'hBF80_0000, 32'h3E80_0000);   // negative: green
        push_pixel(32'h8000_0000, 32'h3F00_0000, 32'h3E80_0000);   // -0 not marked
        push_pixel(32'h3F00_0000, 32'h3F00_0000, 32'hFF80_0000);   // -inf: green
        push_pixel(32'h8000_0001, 32'h0000_0000, 32'h0000_0000);   // neg denormal
        push_pixel(32'h3E00_0000, 32'h3D80_0000, 32'h3C80_0000);   // clean pixel

        // ---- directed: gamma of zero, exposure 4096 ----
        load_settings(4096, 0, 1'b0);
        push_pixel(32'h0080_0000, 32'h3F00_0000, 32'h0000_0000);
        push_pixel(32'h7F7F_FFFF, 32'h7FC0_0000, 32'h8000_0000);

        // ---- directed: exposure -4096, largest inverse gamma ----
        load_settings(-4096, 65535, 1'b0);
        push_pixel(32'h7F7F_FFFF, 32'h4F80_0000, 32'h3F80_0000);
        push_pixel(32'h5F80_0000, 32'h6F00_0000, 32'h0080_0000);
        push_pixel(32'h7F00_0000, 32'h7E80_0000, 32'h7F7F_0000);

        // ---- random phases ----
        // Sender light / receiver heavy first, then swapped, then free flow.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 4)
            begin
                send_idle_pct = 15;
                hold_pct      = 52;
            end
            else if (ph < 7)
            begin
                send_idle_pct = 52;
                hold_pct      = 15;
            end
            else
            begin
                send_idle_pct = 0;
                hold_pct      = 0;
            end

            if (ph == 0)
                load_settings(-4096, 65535, 1'b1);
            else if (ph == 1)
                load_settings(4096, 1, 1'b0);
            else if (ph == 2)
                load_settings(0, 7447, 1'b0);
            else
                load_settings(int'($urandom_range(0, 2048)) - 1024,
                              $urandom_range(2000, 30000), 1'($urandom));

            for (int i = 0; i < PHASE_PIXELS; i++)
            begin
                push_pixel(rand_channel(), rand_channel(), rand_channel());
                // hold off mid-stream until the pipe runs dry
                if (ph == 5 && i == PHASE_PIXELS / 2)
                    wait_pipe_empty();
            end
        end

        wait_pipe_empty();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pixel_sb.pending() != 0)
            pixel_sb.report($sformatf("%0d pixels never came out", pixel_sb.pending()));

        $display("Summary: %0d pixels in, %0d compared, over %0d register settings",
                 pixel_sb.sent, pixel_sb.compared, settings);
        $display("Summary: %0d red-marked, %0d green-marked, %0d full and %0d zero channels",
                 pixel_sb.red_marks, pixel_sb.green_marks,
                 pixel_sb.full_chans, pixel_sb.zero_chans);
        if (pixel_sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/hetm_pkg.sv
sv/hetm_log.sv
sv/hetm_exp.sv
sv/hdr_exposure_gamma_tonemap_core.sv
sv/hetm_checker.sv
tb/sv/tonemap_scoreboard_pkg.sv
tb/sv/testbench.sv
